FILE: rtl/core/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg
// shared constants, codes and types of the k-nearest-neighbor search unit
// ----------------------------------------------------------------------------
package knn_pkg;

    localparam int MAX_VECTORS = 256;
    localparam int MAX_DIM     = 64;
    localparam int MAX_K       = 16;

    localparam int COMP_W   = 16;
    localparam int ID_W     = 9;
    localparam int SCORE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int TOPK_W   = 5;
    localparam int LEN_W    = 7;
    localparam int METRIC_W = 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam int ROW_W  = $clog2(MAX_VECTORS);
    localparam int DIM_W  = $clog2(MAX_DIM);
    localparam int VADR_W = ROW_W + DIM_W;
    localparam int CNT_W  = $clog2(MAX_VECTORS + 1);
    localparam int K_W    = $clog2(MAX_K + 1);
    localparam int KI_W   = (MAX_K > 1) ? $clog2(MAX_K) : 1;

    // accumulator and arithmetic unit widths
    localparam int L2_W   = 39;
    localparam int DOT_W  = 38;
    localparam int NRM_W  = 37;
    localparam int SQ_IN_W  = 48;
    localparam int SQ_OUT_W = 24;
    localparam int DEN_W  = 48;
    localparam int NUM_W  = 54;
    localparam int QUO_W  = 17;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    localparam logic [QUO_W-1:0] ONE_Q16 = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_METRIC = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 1'd1;

    localparam logic [METRIC_W-1:0] METRIC_EUC = 2'd0;
    localparam logic [METRIC_W-1:0] METRIC_IP  = 2'd1;
    localparam logic [METRIC_W-1:0] METRIC_COS = 2'd2;

    localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MATCH    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SINGLE,
        S_COPY,
        S_ROW,
        S_L2_GO,
        S_L2_WAIT,
        S_A_GO,
        S_A_WAIT,
        S_B_GO,
        S_B_WAIT,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_RANK,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic start;
    } unit_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

FILE: rtl/core/knn_if.sv
// ----------------------------------------------------------------------------
// knn channel interfaces
// request and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface knn_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] component;
    logic        last_component;
    logic [4:0]  top_k;

    modport source (output valid, req_type, component, last_component, top_k, input ready);
    modport sink   (input valid, req_type, component, last_component, top_k, output ready);
endinterface

interface knn_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [8:0]  vector_id;
    logic [31:0] score;
    logic        last_result;

    modport source (output valid, status, vector_id, score, last_result, input ready);
    modport sink   (input valid, status, vector_id, score, last_result, output ready);
endinterface

FILE: rtl/core/knn_isqrt.sv
// ----------------------------------------------------------------------------
// knn_isqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module knn_isqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  knn_pkg::unit_ctl_t            ctl,
    input  logic [knn_pkg::SQ_IN_W-1:0]   x_in,
    output knn_pkg::unit_sts_t            sts,
    output logic [knn_pkg::SQ_OUT_W-1:0]  root
);
    import knn_pkg::*;

    logic [SQ_IN_W-1:0] x_reg, x_next;
    logic [SQ_IN_W-1:0] r_reg, r_next;
    logic [SQ_IN_W-1:0] bit_reg, bit_next;
    logic               busy_reg, done_reg;
    logic [SQ_IN_W-1:0] trial;

    always_comb
    begin
        trial = r_reg + bit_reg;
        if (x_reg >= trial)
        begin
            x_next = x_reg - trial;
            r_next = (r_reg >> 1) + bit_reg;
        end
        else
        begin
            x_next = x_reg;
            r_next = r_reg >> 1;
        end
        bit_next = bit_reg >> 2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            x_reg   <= x_in;
            r_reg   <= '0;
            bit_reg <= SQ_IN_W'(1) << (SQ_IN_W - 2);
        end
        else if (busy_reg)
        begin
            x_reg   <= x_next;
            r_reg   <= r_next;
            bit_reg <= bit_next;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign root     = r_reg[SQ_OUT_W-1:0];

endmodule

FILE: rtl/core/knn_div.sv
// ----------------------------------------------------------------------------
// knn_div
// restoring divider, one quotient bit per cycle, quotient clamped to 1.0
// ----------------------------------------------------------------------------
module knn_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  knn_pkg::unit_ctl_t           ctl,
    input  logic [knn_pkg::NUM_W-1:0]    num,
    input  logic [knn_pkg::DEN_W-1:0]    den,
    output knn_pkg::unit_sts_t           sts,
    output logic [knn_pkg::QUO_W-1:0]    quo
);
    import knn_pkg::*;

    logic [NUM_W-1:0]     n_reg;
    logic [DEN_W-1:0]     d_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [NUM_W-1:0]     q_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg, done_reg;
    logic [DEN_W:0]       sh;
    logic                 ge;

    always_comb
    begin
        sh = {rem_reg, n_reg[NUM_W-1]};
        ge = (sh >= {1'b0, d_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            n_reg   <= num;
            d_reg   <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            n_reg   <= n_reg << 1;
            rem_reg <= ge ? DEN_W'(sh - {1'b0, d_reg}) : sh[DEN_W-1:0];
            q_reg   <= {q_reg[NUM_W-2:0], ge};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quo = (q_reg > NUM_W'(ONE_Q16)) ? ONE_Q16 : q_reg[QUO_W-1:0];

endmodule

FILE: rtl/core/brute_force_knn_search_unit.sv
// ----------------------------------------------------------------------------
// brute_force_knn_search_unit
// exhaustive k-nearest-neighbor search over a store of Q4.12 vectors
// ----------------------------------------------------------------------------
// request channel: one component per word; last_component closes a vector,
// req_type on that word picks store or query, top_k is sampled there too.
// result channel: one word per store or error, per query min(stored, top_k)
// matches, top_k clamped to 1..MAX_K, best first; last_result ends a request.
// config port: wr_en/wr_index/wr_data, write only while the unit is idle.
// component words are taken at one per cycle while the unit is idle. closing
// a store copies every staging word, zero past the length, into vector memory.
// a query walks every stored row through the single vector memory read port:
// per row the components stream through, then a square root for euclidean,
// two roots, a multiply and a divide for cosine (none on a zero norm), nothing
// for inner product; then a ranking step for that row.
// reset clears the store count, the counters and the output valid flag; the
// memories keep their contents, and no unwritten word is ever used.
// a stalled result channel holds the output word; the unit waits only when it has a next word to load.
// ----------------------------------------------------------------------------
module brute_force_knn_search_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [knn_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [knn_pkg::CFG_DATA_W-1:0]    wr_data,
    knn_req_if.sink                           request,
    knn_rsp_if.source                         result
);
    import knn_pkg::*;

    // configuration
    logic [METRIC_W-1:0] metric_reg;
    logic [LEN_W-1:0]    length_reg;

    // control
    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    ccnt_reg;
    logic                overrun_reg;
    logic [CNT_W-1:0]    stored_reg;
    logic [CNT_W-1:0]    row_reg;
    logic [K_W-1:0]      topk_reg;
    logic [K_W-1:0]      n_reg;
    logic [K_W-1:0]      emit_reg;
    logic [LEN_W-1:0]    cp_reg;
    logic                cp_v_reg;
    logic [DIM_W-1:0]    cp_idx_reg;
    logic [LEN_W-1:0]    iss_reg;
    logic                rd_v_reg, rd_last_reg;
    logic                prod_v_reg, prod_last_reg;
    logic                acc_done_reg;
    logic                out_v_reg;
    logic [STATUS_W-1:0] pend_status_reg;
    logic [ID_W-1:0]     pend_id_reg;

    // datapath
    logic [COMP_W-1:0]   qbuf_mem [MAX_DIM];
    logic [COMP_W-1:0]   vec_mem  [MAX_VECTORS*MAX_DIM];
    logic [COMP_W-1:0]   qrd_reg, vrd_reg;
    logic [31:0]         pdd_reg, pqq_reg, pvv_reg;
    logic signed [31:0]  pqv_reg;
    logic [L2_W-1:0]     acc_l2_reg;
    logic signed [DOT_W-1:0] acc_dot_reg;
    logic [NRM_W-1:0]    acc_na_reg, acc_nb_reg;
    logic [SQ_OUT_W-1:0] sa_reg, sb_reg;
    logic [DEN_W-1:0]    den_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic signed [SCORE_W-1:0] best_scores [MAX_K];
    logic [ID_W-1:0]     best_ids [MAX_K];
    logic [STATUS_W-1:0] out_status_reg;
    logic [ID_W-1:0]     out_id_reg;
    logic [SCORE_W-1:0]  out_score_reg;
    logic                out_last_reg;

    // combinational
    logic                in_fire, fin;
    logic [LEN_W-1:0]    count_now;
    logic                overrun_now, mismatch, full;
    logic [K_W-1:0]      topk_clamped;
    logic                slot_free, out_load;
    logic [STATUS_W-1:0] load_status;
    logic [ID_W-1:0]     load_id;
    logic [SCORE_W-1:0]  load_score;
    logic                load_last;
    logic                issue;
    logic                is_ip, is_cos, zero_norm;
    logic [DIM_W-1:0]    qaddr;
    logic [VADR_W-1:0]   vaddr;
    logic signed [16:0]  dq;
    logic signed [33:0]  dd;
    logic [MAX_K-1:0]    ins;
    logic                asc;
    unit_ctl_t           sq_ctl, dv_ctl;
    unit_sts_t           sq_sts, dv_sts;
    logic [SQ_IN_W-1:0]  sq_in;
    logic [SQ_OUT_W-1:0] sq_root;
    logic [QUO_W-1:0]    dv_quo;
    logic [NUM_W-1:0]    dv_num;
    logic [DOT_W-1:0]    dot_mag;

    assign in_fire     = request.valid && request.ready;
    assign fin         = in_fire && request.last_component;
    assign overrun_now = overrun_reg || (ccnt_reg == 7'd127);
    assign count_now   = (ccnt_reg == 7'd127) ? ccnt_reg : ccnt_reg + 1'b1;
    assign mismatch    = overrun_now || (count_now != length_reg)
                         || (length_reg > LEN_W'(MAX_DIM));
    assign full        = (stored_reg >= CNT_W'(MAX_VECTORS));
    assign is_ip       = (metric_reg == METRIC_IP);
    assign is_cos      = (metric_reg == METRIC_COS);
    assign asc         = !is_ip;
    assign zero_norm   = (acc_na_reg == '0) || (acc_nb_reg == '0);
    assign slot_free   = !out_v_reg || result.ready;

    always_comb
    begin
        if (request.top_k == '0)
            topk_clamped = K_W'(1);
        else if (request.top_k > TOPK_W'(MAX_K))
            topk_clamped = K_W'(MAX_K);
        else
            topk_clamped = K_W'(request.top_k);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (fin)
                begin
                    if (mismatch)
                        state_next = S_SINGLE;
                    else if (!request.req_type)
                        state_next = full ? S_SINGLE : S_COPY;
                    else
                        state_next = (stored_reg == '0) ? S_SINGLE : S_ROW;
                end
            end
            S_SINGLE:   if (slot_free) state_next = S_IDLE;
            S_COPY:     if (cp_v_reg && cp_idx_reg == DIM_W'(MAX_DIM - 1)) state_next = S_SINGLE;
            S_ROW:
            begin
                if (acc_done_reg)
                begin
                    if (is_ip)
                        state_next = S_RANK;
                    else if (is_cos)
                        state_next = zero_norm ? S_RANK : S_A_GO;
                    else
                        state_next = S_L2_GO;
                end
            end
            S_L2_GO:    state_next = S_L2_WAIT;
            S_L2_WAIT:  if (sq_sts.done) state_next = S_RANK;
            S_A_GO:     state_next = S_A_WAIT;
            S_A_WAIT:   if (sq_sts.done) state_next = S_B_GO;
            S_B_GO:     state_next = S_B_WAIT;
            S_B_WAIT:   if (sq_sts.done) state_next = S_MUL;
            S_MUL:      state_next = S_DIV_GO;
            S_DIV_GO:   state_next = S_DIV_WAIT;
            S_DIV_WAIT: if (dv_sts.done) state_next = S_RANK;
            S_RANK:     state_next = (row_reg + 1'b1 < stored_reg) ? S_ROW : S_EMIT;
            S_EMIT:     if (slot_free && emit_reg + 1'b1 == n_reg) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        request.ready = (state_reg == S_IDLE);
        issue         = (state_reg == S_ROW) && (iss_reg < length_reg);
        sq_ctl.start  = (state_reg == S_L2_GO) || (state_reg == S_A_GO)
                        || (state_reg == S_B_GO);
        dv_ctl.start  = (state_reg == S_DIV_GO);
        out_load      = 1'b0;
        load_status   = pend_status_reg;
        load_id       = pend_id_reg;
        load_score    = '0;
        load_last     = 1'b1;
        if (state_reg == S_SINGLE)
        begin
            out_load = slot_free;
        end
        else if (state_reg == S_EMIT)
        begin
            out_load    = slot_free;
            load_status = ST_MATCH;
            load_id     = best_ids[emit_reg[KI_W-1:0]];
            load_score  = best_scores[emit_reg[KI_W-1:0]];
            load_last   = (emit_reg + 1'b1 == n_reg);
        end
    end

    assign qaddr = (state_reg == S_COPY) ? cp_reg[DIM_W-1:0] : iss_reg[DIM_W-1:0];
    assign vaddr = {row_reg[ROW_W-1:0], iss_reg[DIM_W-1:0]};

    always_comb
    begin
        unique case (state_reg)
            S_L2_GO: sq_in = {1'b0, acc_l2_reg, 8'b0};
            S_A_GO:  sq_in = {3'b0, acc_na_reg, 8'b0};
            default: sq_in = {3'b0, acc_nb_reg, 8'b0};
        endcase
    end

    assign dot_mag = acc_dot_reg[DOT_W-1] ? DOT_W'(-acc_dot_reg) : DOT_W'(acc_dot_reg);
    assign dv_num  = {dot_mag[NUM_W-17:0], 16'b0};

    assign dq = $signed({qrd_reg[COMP_W-1], qrd_reg}) - $signed({vrd_reg[COMP_W-1], vrd_reg});
    assign dd = dq * dq;

    // insertion position flags, one per list cell
    always_comb
    begin
        for (int j = 0; j < MAX_K; j++)
        begin
            if (K_W'(j) < n_reg)
                ins[j] = asc ? (score_reg < best_scores[j]) : (score_reg > best_scores[j]);
            else
                ins[j] = (K_W'(j) == n_reg);
        end
    end

    knn_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sq_ctl),
        .x_in  (sq_in),
        .sts   (sq_sts),
        .root  (sq_root)
    );

    knn_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (dv_ctl),
        .num   (dv_num),
        .den   (den_reg),
        .sts   (dv_sts),
        .quo   (dv_quo)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            metric_reg    <= METRIC_EUC;
            length_reg    <= LEN_W'(MAX_DIM);
            ccnt_reg      <= '0;
            overrun_reg   <= 1'b0;
            stored_reg    <= '0;
            row_reg       <= '0;
            topk_reg      <= '0;
            n_reg         <= '0;
            emit_reg      <= '0;
            cp_reg        <= '0;
            cp_v_reg      <= 1'b0;
            iss_reg       <= '0;
            rd_v_reg      <= 1'b0;
            rd_last_reg   <= 1'b0;
            prod_v_reg    <= 1'b0;
            prod_last_reg <= 1'b0;
            acc_done_reg  <= 1'b0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    CFG_METRIC: metric_reg <= wr_data[METRIC_W-1:0];
                    CFG_LENGTH: length_reg <= wr_data[LEN_W-1:0];
                endcase
            end

            if (in_fire)
            begin
                if (request.last_component)
                begin
                    ccnt_reg    <= '0;
                    overrun_reg <= 1'b0;
                    topk_reg    <= topk_clamped;
                    n_reg       <= '0;
                    row_reg     <= '0;
                end
                else if (ccnt_reg == 7'd127)
                    overrun_reg <= 1'b1;
                else
                    ccnt_reg <= ccnt_reg + 1'b1;
            end

            // staging buffer to vector memory copy
            if (state_reg == S_COPY && cp_reg < LEN_W'(MAX_DIM))
                cp_reg <= cp_reg + 1'b1;
            else if (state_reg == S_IDLE)
                cp_reg <= '0;
            cp_v_reg <= (state_reg == S_COPY) && (cp_reg < LEN_W'(MAX_DIM));
            if (cp_v_reg && cp_idx_reg == DIM_W'(MAX_DIM - 1))
                stored_reg <= stored_reg + 1'b1;

            // row streaming pipeline
            if (state_reg == S_IDLE || state_reg == S_RANK)
                iss_reg <= '0;
            else if (issue)
                iss_reg <= iss_reg + 1'b1;
            rd_v_reg      <= issue;
            rd_last_reg   <= issue && (iss_reg + 1'b1 == length_reg);
            prod_v_reg    <= rd_v_reg;
            prod_last_reg <= rd_v_reg && rd_last_reg;
            if (state_reg == S_IDLE || state_reg == S_RANK)
                acc_done_reg <= 1'b0;
            else if (prod_v_reg && prod_last_reg)
                acc_done_reg <= 1'b1;

            if (state_reg == S_RANK)
            begin
                row_reg <= row_reg + 1'b1;
                if (n_reg < topk_reg)
                    n_reg <= n_reg + 1'b1;
                emit_reg <= '0;
            end
            else if (state_reg == S_EMIT && slot_free)
                emit_reg <= emit_reg + 1'b1;

            if (out_load)
                out_v_reg <= 1'b1;
            else if (result.ready)
                out_v_reg <= 1'b0;
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (in_fire && ccnt_reg < LEN_W'(MAX_DIM))
            qbuf_mem[ccnt_reg[DIM_W-1:0]] <= request.component;
        qrd_reg <= qbuf_mem[qaddr];
    end

    always_ff @(posedge clk)
    begin
        if (cp_v_reg)
            vec_mem[{stored_reg[ROW_W-1:0], cp_idx_reg}] <=
                (LEN_W'(cp_idx_reg) < length_reg) ? qrd_reg : '0;
        vrd_reg <= vec_mem[vaddr];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cp_idx_reg <= cp_reg[DIM_W-1:0];

        if (fin)
        begin
            if (mismatch)
            begin
                pend_status_reg <= ST_MISMATCH;
                pend_id_reg     <= '0;
            end
            else if (!request.req_type)
            begin
                pend_status_reg <= full ? ST_FULL : ST_STORED;
                pend_id_reg     <= full ? '0 : ID_W'(stored_reg + 1'b1);
            end
            else
            begin
                pend_status_reg <= ST_EMPTY;
                pend_id_reg     <= '0;
            end
        end

        if (rd_v_reg)
        begin
            pdd_reg <= dd[31:0];
            pqv_reg <= $signed(qrd_reg) * $signed(vrd_reg);
            pqq_reg <= 32'($signed(qrd_reg) * $signed(qrd_reg));
            pvv_reg <= 32'($signed(vrd_reg) * $signed(vrd_reg));
        end

        if (state_reg == S_IDLE || state_reg == S_RANK)
        begin
            acc_l2_reg  <= '0;
            acc_dot_reg <= '0;
            acc_na_reg  <= '0;
            acc_nb_reg  <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_l2_reg  <= acc_l2_reg + {7'b0, pdd_reg};
            acc_dot_reg <= acc_dot_reg + {{(DOT_W-32){pqv_reg[31]}}, pqv_reg};
            acc_na_reg  <= acc_na_reg + {5'b0, pqq_reg};
            acc_nb_reg  <= acc_nb_reg + {5'b0, pvv_reg};
        end

        if (state_reg == S_ROW && acc_done_reg)
        begin
            if (is_ip)
                score_reg <= SCORE_W'(acc_dot_reg >>> 8);
            else
                score_reg <= SCORE_W'(ONE_Q16);
        end
        else if (state_reg == S_L2_WAIT && sq_sts.done)
            score_reg <= SCORE_W'(sq_root);
        else if (state_reg == S_DIV_WAIT && dv_sts.done)
        begin
            if (acc_dot_reg[DOT_W-1])
                score_reg <= SCORE_W'(ONE_Q16) + SCORE_W'(dv_quo);
            else
                score_reg <= SCORE_W'(ONE_Q16) - SCORE_W'(dv_quo);
        end

        if (state_reg == S_A_WAIT && sq_sts.done)
            sa_reg <= sq_root;
        if (state_reg == S_B_WAIT && sq_sts.done)
            sb_reg <= sq_root;
        if (state_reg == S_MUL)
            den_reg <= DEN_W'(sa_reg * sb_reg);

        // sorted best list, each cell takes new score, left neighbor or holds
        if (state_reg == S_RANK)
        begin
            for (int j = 0; j < MAX_K; j++)
            begin
                if (K_W'(j) < topk_reg && ins[j])
                begin
                    if (j == 0 || !ins[(j == 0) ? 0 : j - 1])
                    begin
                        best_scores[j] <= score_reg;
                        best_ids[j]    <= ID_W'(row_reg + 1'b1);
                    end
                    else
                    begin
                        best_scores[j] <= best_scores[(j == 0) ? 0 : j - 1];
                        best_ids[j]    <= best_ids[(j == 0) ? 0 : j - 1];
                    end
                end
            end
        end

        if (out_load)
        begin
            out_status_reg <= load_status;
            out_id_reg     <= load_id;
            out_score_reg  <= load_score;
            out_last_reg   <= load_last;
        end
    end

    assign result.valid       = out_v_reg;
    assign result.status      = out_status_reg;
    assign result.vector_id   = out_id_reg;
    assign result.score       = out_score_reg;
    assign result.last_result = out_last_reg;

    a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= CNT_W'(MAX_VECTORS))
        else $error("store count beyond capacity");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> n_reg != '0 && n_reg <= topk_reg)
        else $error("match list count out of range");

    a_sqrt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sq_ctl.start |-> !sq_sts.busy)
        else $error("square root restarted while busy");

    a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
        dv_ctl.start |-> den_reg != '0 && !dv_sts.busy)
        else $error("divide started with zero divisor or while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> slot_free)
        else $error("output word overwritten");

endmodule

FILE: bench/knn_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_result_checker
// watches the request, result and config ports of the search unit, keeps its
// own copy of the vector store, predicts every result word and compares
// ----------------------------------------------------------------------------
module knn_result_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [knn_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [knn_pkg::CFG_DATA_W-1:0] wr_data,
    knn_req_if                             req,
    knn_rsp_if                             rsp,
    output int                             pending,
    output int                             errors,
    output int                             checked
);
    import knn_pkg::*;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     vector_id;
        logic [SCORE_W-1:0]  score;
        logic                last_result;
    } result_word_t;

    result_word_t        expected_words[$];
    logic [COMP_W-1:0]   store_mem [MAX_VECTORS][MAX_DIM];
    logic [COMP_W-1:0]   staging [MAX_DIM];
    int                  n_stored;
    int                  comp_cnt;
    bit                  overrun;
    logic [METRIC_W-1:0] metric;
    int                  vec_len;
    longint              rank_score [MAX_K];
    int                  rank_id [MAX_K];

    assign pending = expected_words.size();

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint row_score(int row);
        longint unsigned l2;
        longint unsigned na;
        longint unsigned nb;
        longint unsigned sa;
        longint unsigned sb;
        longint unsigned den;
        longint unsigned mag;
        longint unsigned q0;
        longint unsigned rem;
        longint unsigned m;
        longint dot;
        longint q;
        longint v;
        longint s;
        l2 = 0;
        na = 0;
        nb = 0;
        dot = 0;
        for (int i = 0; i < vec_len && i < MAX_DIM; i++)
        begin
            q = longint'($signed(staging[i]));
            v = longint'($signed(store_mem[row][i]));
            l2 += (q - v) * (q - v);
            dot += q * v;
            na += q * q;
            nb += v * v;
        end
        if (metric == METRIC_IP)
        begin
            s = (dot >= 0) ? (dot >>> 8) : -((-dot + 255) >>> 8);
            if (s > 64'sd2147483647)
                s = 64'sd2147483647;
            if (s < -64'sd2147483648)
                s = -64'sd2147483648;
            return s;
        end
        if (metric == METRIC_COS)
        begin
            // zero norm scores as 1.0
            if (na == 0 || nb == 0)
                return longint'(ONE_Q16);
            sa = int_sqrt(na << 8);
            sb = int_sqrt(nb << 8);
            den = sa * sb;
            mag = (dot >= 0) ? dot : -dot;
            q0 = mag / den;
            rem = mag % den;
            if (q0 >= 2)
                m = ONE_Q16;
            else
            begin
                m = q0;
                for (int k = 0; k < 24; k++)
                begin
                    rem <<= 1;
                    m <<= 1;
                    if (rem >= den)
                    begin
                        rem -= den;
                        m |= 1;
                    end
                end
                m >>= 8;
                if (m > ONE_Q16)
                    m = ONE_Q16;
            end
            return (dot >= 0) ? longint'(ONE_Q16) - longint'(m)
                              : longint'(ONE_Q16) + longint'(m);
        end
        return longint'(int_sqrt(l2 << 8));
    endfunction

    function automatic void push_word(logic [STATUS_W-1:0] st, int id, longint sc, bit last);
        result_word_t w;
        w.status = st;
        w.vector_id = id[ID_W-1:0];
        w.score = sc[SCORE_W-1:0];
        w.last_result = last;
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic void accept_component(bit is_query, logic [COMP_W-1:0] comp, bit last,
                                             logic [TOPK_W-1:0] top_k);
        int  cnt;
        int  k;
        int  n;
        int  pos;
        bit  asc;
        longint s;
        if (comp_cnt < MAX_DIM)
            staging[comp_cnt] = comp;
        if (comp_cnt < 127)
            comp_cnt++;
        else
            overrun = 1;
        if (!last)
            return;
        cnt = comp_cnt;
        comp_cnt = 0;
        if (overrun || cnt != vec_len || vec_len > MAX_DIM)
        begin
            overrun = 0;
            push_word(ST_MISMATCH, 0, 0, 1);
            return;
        end
        if (!is_query)
        begin
            if (n_stored >= MAX_VECTORS)
            begin
                push_word(ST_FULL, 0, 0, 1);
                return;
            end
            for (int i = 0; i < MAX_DIM; i++)
                store_mem[n_stored][i] = (i < vec_len) ? staging[i] : '0;
            n_stored++;
            push_word(ST_STORED, n_stored, 0, 1);
            return;
        end
        if (n_stored == 0)
        begin
            push_word(ST_EMPTY, 0, 0, 1);
            return;
        end
        k = (top_k == 0) ? 1 : ((top_k > MAX_K) ? MAX_K : int'(top_k));
        asc = (metric != METRIC_IP);
        n = 0;
        for (int r = 0; r < n_stored; r++)
        begin
            s = row_score(r);
            pos = n;
            while (pos > 0 && (asc ? s < rank_score[pos-1] : s > rank_score[pos-1]))
                pos--;
            if (pos >= k)
                continue;
            if (n < k)
                n++;
            for (int i = n - 1; i > pos; i--)
            begin
                rank_score[i] = rank_score[i-1];
                rank_id[i] = rank_id[i-1];
            end
            rank_score[pos] = s;
            rank_id[pos] = r + 1;
        end
        for (int i = 0; i < n; i++)
            push_word(ST_MATCH, rank_id[i], rank_score[i], i + 1 == n);
    endfunction

    task automatic report(string field, logic [31:0] want, logic [31:0] got);
        $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, field, want, got);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_word_t w;
        if (!rst_n)
        begin
            expected_words.delete();
            n_stored = 0;
            comp_cnt = 0;
            overrun = 0;
            metric = METRIC_EUC;
            vec_len = MAX_DIM;
            errors = 0;
            checked = 0;
        end
        else
        begin
            if (wr_en)
            begin
                if (wr_index == CFG_METRIC)
                    metric = wr_data[METRIC_W-1:0];
                else
                    vec_len = int'(wr_data);
            end
            if (rsp.valid && rsp.ready)
            begin
                checked++;
                if (expected_words.size() == 0)
                    report("unexpected word", 32'd0, 32'(rsp.status));
                else
                begin
                    w = expected_words.pop_front();
                    if (rsp.status !== w.status)
                        report("status", 32'(w.status), 32'(rsp.status));
                    if (rsp.vector_id !== w.vector_id)
                        report("vector_id", 32'(w.vector_id), 32'(rsp.vector_id));
                    if (rsp.score !== w.score)
                        report("score", w.score, rsp.score);
                    if (rsp.last_result !== w.last_result)
                        report("last_result", 32'(w.last_result), 32'(rsp.last_result));
                end
            end
            if (req.valid && req.ready)
                accept_component(req.req_type, req.component, req.last_component, req.top_k);
        end
    end

endmodule

FILE: bench/tb_brute_force_knn_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_brute_force_knn_search_unit
// drives store and query vectors under every metric and several lengths,
// with random gaps on both channels; the checker predicts and compares
// ----------------------------------------------------------------------------
module tb_brute_force_knn_search_unit;
    import knn_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;
    int                    pending;
    int                    errors;
    int                    checked;
    int                    vectors_sent;
    int                    words_sent;
    bit                    quiet;
    bit                    stall_now;
    bit                    stall_done;
    int                    hold_cnt;
    int                    rsp_gap;

    knn_req_if req_ch();
    knn_rsp_if rsp_ch();

    brute_force_knn_search_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .request  (req_ch),
        .result   (rsp_ch)
    );

    knn_result_checker i_checker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .pending  (pending),
        .errors   (errors),
        .checked  (checked)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [COMP_W-1:0] pick_comp();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3, 4: return 16'($urandom_range(0, 8192) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    // result side: random stalls plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_cnt = 0;
            rsp_gap = 0;
            stall_done = 0;
        end
        else
        begin
            if (stall_now && !stall_done)
            begin
                stall_done = 1;
                hold_cnt = 600;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rsp_ch.ready <= 1'b0;
            end
            else if (rsp_gap > 0)
            begin
                rsp_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    rsp_gap = pick_gap();
            end
        end
    end

    task automatic send_word(bit rt, logic [COMP_W-1:0] comp, bit last, logic [TOPK_W-1:0] k);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= rt;
        req_ch.component <= comp;
        req_ch.last_component <= last;
        req_ch.top_k <= k;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // non-final words get a random word type, the final one decides
    task automatic send_vector(bit rt, int n, logic [TOPK_W-1:0] k, bit fixed_comp,
                               logic [COMP_W-1:0] comp);
        for (int i = 0; i < n; i++)
            send_word((i == n - 1) ? rt : 1'($urandom), fixed_comp ? comp : pick_comp(),
                      i == n - 1, (i == n - 1) ? k : 5'($urandom));
        vectors_sent++;
    endtask

    // the checker sees the last accepted word before pending is polled
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_config(logic [METRIC_W-1:0] m, int len);
        wait_idle();
        wr_en <= 1'b1;
        wr_index <= CFG_METRIC;
        wr_data <= CFG_DATA_W'(m);
        @(posedge clk);
        wr_index <= CFG_LENGTH;
        wr_data <= CFG_DATA_W'(len);
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    initial
    begin
        logic [METRIC_W-1:0] m;
        int len;
        int wait_cnt;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = CFG_METRIC;
        wr_data = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = 1'b0;
        req_ch.component = '0;
        req_ch.last_component = 1'b0;
        req_ch.top_k = '0;
        quiet = 0;
        stall_now = 0;
        vectors_sent = 0;
        words_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store, extremes, zero vector, top_k limits, bad lengths
        set_config(METRIC_EUC, 4);
        send_vector(1, 4, 5'd4, 0, 0);
        send_vector(0, 4, 5'd1, 1, 16'h8000);
        send_vector(0, 4, 5'd1, 1, 16'h7fff);
        send_vector(0, 4, 5'd1, 1, 16'h0000);
        send_vector(1, 4, 5'd0, 1, 16'h7fff);
        send_vector(1, 4, 5'd31, 1, 16'h8000);
        send_vector(0, 3, 5'd1, 0, 0);
        send_vector(1, 5, 5'd2, 0, 0);
        set_config(METRIC_COS, 4);
        send_vector(1, 4, 5'd16, 1, 16'h0000);
        send_vector(1, 4, 5'd3, 1, 16'h8000);
        set_config(METRIC_IP, 1);
        send_vector(0, 1, 5'd1, 1, 16'h8000);
        send_vector(1, 1, 5'd16, 1, 16'h8000);

        // random phases over all metric codes and short lengths
        for (int p = 0; p < 4; p++)
        begin
            m = METRIC_W'(p);
            len = $urandom_range(1, 3);
            set_config(m, len);
            quiet = (p == 1);
            if (p == 3)
            begin
                // sender waits for this store's result before going on
                send_vector(0, len, 5'd1, 0, 0);
                wait_idle();
            end
            if (p == 2)
                stall_now <= 1'b1;
            for (int v = 0; v < 6; v++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_vector(1'($urandom), $urandom_range(1, 4), 5'($urandom), 0, 0);
                else
                    send_vector($urandom_range(0, 9) < 4 ? 1'b0 : 1'b1, len,
                                5'($urandom), 0, 0);
            end
        end
        quiet = 0;

        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 200000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (200) @(posedge clk);
        $display("covered %0d vectors in %0d words, all metric codes, lengths 1 to 5,",
                 vectors_sent, words_sent);
        $display("empty store, length errors, top_k limits, long stall; %0d words checked",
                 checked);
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
